### design/pqe_pkg.sv
// Shared field widths, action codes and status codes of the positional queue engine.
package pqe_pkg;

    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;

    localparam action_t ACT_PUSH    = 3'd0;
    localparam action_t ACT_POP     = 3'd1;
    localparam action_t ACT_INS_AT  = 3'd2;
    localparam action_t ACT_DEL_AT  = 3'd3;
    localparam action_t ACT_DEL_RUN = 3'd4;
    localparam action_t ACT_SEARCH  = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

### design/positional_queue_engine.sv
// Top level: sequencer that runs queue actions over one shared RAM port pair.
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------------------
//   command  | start, busy         | action, value, position, run_length
//   result   | done (one cycle)    | status, found, fill_count, head_value
//
// A command is taken at a clock edge with start high and busy low.
// Push, rejected actions and unknown actions go from decode straight to the head fetch and report.
// Insert, delete and search stream one entry per cycle through the RAM
// read/write port pair.
// Reset clears the fill count; entry storage is not cleared.
// The receiver cannot stall: done is a one-cycle strobe; busy is high
// until the result is registered.
module positional_queue_engine #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pqe_pkg::ACTION_W-1:0] action,
    input  logic signed [pqe_pkg::WORD_W-1:0] value,
    input  logic [pqe_pkg::POS_W-1:0]    position,
    input  logic [pqe_pkg::POS_W-1:0]    run_length,
    output logic                         done,
    output logic [pqe_pkg::STATUS_W-1:0] status,
    output logic                         found,
    output logic [pqe_pkg::FILL_W-1:0]   fill_count,
    output logic signed [pqe_pkg::WORD_W-1:0] head_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW >= pqe_pkg::POS_W) ? CW : pqe_pkg::POS_W) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          len_reg, len_next;
    logic [CW-1:0]          dst_reg, dst_next;
    logic                   pend_reg, pend_next;
    logic                   ins_reg, ins_next;
    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    pqe_pkg::status_t       status_reg, status_next;
    pqe_pkg::word_t         value_reg, value_next;
    pqe_pkg::word_t         head_reg, head_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    pqe_pkg::word_t         ram_wdata;
    logic [AW-1:0]          ram_raddr;
    pqe_pkg::word_t         ram_rdata;

    logic [XW-1:0]          cnt_x, pos_x, req_x, avail_x, len_x, del_cur_x;
    logic                   full, ins_bad, del_bad, issue;
    logic [CW-1:0]          rd_addr;

    pqe_ram #(
        .WIDTH (pqe_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode position checks and the clamped run length of a new command
    always_comb
    begin
        cnt_x     = XW'(count_reg);
        pos_x     = (action == pqe_pkg::ACT_POP) ? XW'(1) : XW'(position);
        req_x     = (action == pqe_pkg::ACT_DEL_RUN) ? XW'(run_length) : XW'(1);
        avail_x   = cnt_x - pos_x + XW'(1);
        len_x     = (req_x > avail_x) ? avail_x : req_x;
        del_cur_x = pos_x - XW'(1) + len_x;
        full      = (count_reg == CW'(DEPTH));
        ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
        del_bad   = (pos_x == '0) || (pos_x > cnt_x);
    end

    // Read address and stream condition of the shift and search loops
    always_comb
    begin
        rd_addr = ins_reg ? (cur_reg - CW'(1)) : cur_reg;
        if (state_reg == S_SHIFT && ins_reg)
        begin
            issue = (cur_reg >= pos_reg);
        end
        else
        begin
            issue = (cur_reg < count_reg);
        end
    end

    // Sequence one command: decode, stream entries, fetch the head, report
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        ins_next    = ins_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        status_next = status_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = value;
        ram_raddr   = rd_addr[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = pqe_pkg::ST_OK;
                    found_next  = 1'b0;
                    value_next  = value;
                    pend_next   = 1'b0;
                    state_next  = S_HEAD;
                    case (action) inside
                        pqe_pkg::ACT_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = pqe_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pqe_pkg::ACT_INS_AT:
                        begin
                            if (full)
                            begin
                                status_next = pqe_pkg::ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                status_next = pqe_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ins_next   = 1'b1;
                                cur_next   = count_reg;
                                pos_next   = pos_x[CW-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                        pqe_pkg::ACT_POP, pqe_pkg::ACT_DEL_AT, pqe_pkg::ACT_DEL_RUN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = pqe_pkg::ST_EMPTY;
                            end
                            else if (del_bad)
                            begin
                                status_next = pqe_pkg::ST_RANGE;
                            end
                            else if (len_x != '0)
                            begin
                                ins_next   = 1'b0;
                                cur_next   = del_cur_x[CW-1:0];
                                len_next   = len_x[CW-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                        pqe_pkg::ACT_SEARCH:
                        begin
                            ins_next   = 1'b0;
                            cur_next   = '0;
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_HEAD;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // Drain the word fetched last cycle into its new slot
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ram_we    = pend_reg;
                pend_next = issue;
                if (issue)
                begin
                    dst_next = ins_reg ? cur_reg : (cur_reg - len_reg);
                    cur_next = ins_reg ? (cur_reg - CW'(1)) : (cur_reg + CW'(1));
                end
                else if (!pend_reg)
                begin
                    // Drop the new word in, or shrink the queue
                    if (ins_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(pos_reg - CW'(1));
                        ram_wdata  = value_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - len_reg;
                    end
                    state_next = S_HEAD;
                end
            end
            S_SEARCH:
            begin
                // Compare the word fetched last cycle and advance the scan
                if (pend_reg && (ram_rdata == value_reg))
                begin
                    found_next = 1'b1;
                end
                pend_next = issue;
                if (issue)
                begin
                    cur_next = cur_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                ram_raddr  = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                head_next  = (count_reg != '0) ? ram_rdata : '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cur_reg    <= '0;
            pend_reg   <= 1'b0;
            ins_reg    <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= pqe_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            pend_reg   <= pend_next;
            ins_reg    <= ins_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        len_reg   <= len_next;
        dst_reg   <= dst_next;
        value_reg <= value_next;
        head_reg  <= head_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign fill_count = pqe_pkg::FILL_W'(count_reg);
    assign head_value = head_reg;

`ifndef NO_ASSERTIONS
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_OUT))
        else $error("result strobe without a finished command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == pqe_pkg::ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with room left");

    a_search_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |=> $stable(count_reg))
        else $error("search changed the fill count");
`endif

endmodule

### design/pqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word and register one read each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/queue_result_checker.sv
// Checker that predicts every queue result and compares it with the engine's output.
module queue_result_checker
    import pqe_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  action_t             action,
    input  word_t               value,
    input  logic [POS_W-1:0]    position,
    input  logic [POS_W-1:0]    run_length,
    input  logic                done,
    input  status_t             status,
    input  logic                found,
    input  logic [FILL_W-1:0]   fill_count,
    input  word_t               head_value,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t             status;
        logic                found;
        logic [FILL_W-1:0]   fill;
        word_t               head;
    } queue_result_t;

    queue_result_t due_results[$];
    word_t         slots [DEPTH];
    int unsigned   held = 0;
    int            mismatches = 0;

    assign fail_count = mismatches;

    // Close the gap left by removing len entries from first.
    function automatic void drop_span(input int unsigned first, input int unsigned len);
        for (int unsigned i = first; i + len < held; i++)
            slots[i] = slots[i + len];
        held = held - len;
    endfunction

    // Apply one command to the shadow queue and return the result it must give.
    function automatic queue_result_t apply_command(input action_t act, input word_t val,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [POS_W-1:0] run);
        queue_result_t r;
        int unsigned   p;
        int unsigned   len;
        int unsigned   avail;
        r = '0;
        r.status = ST_OK;
        p = pos;
        case (act)
            ACT_PUSH: begin
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slots[held] = val;
                    held++;
                end
            end
            ACT_POP: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                    drop_span(0, 1);
            end
            ACT_INS_AT: begin
                // full wins over a bad position
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else if (p < 1 || p > held + 1)
                    r.status = ST_RANGE;
                else
                begin
                    for (int unsigned i = held; i > p - 1; i--)
                        slots[i] = slots[i - 1];
                    slots[p - 1] = val;
                    held++;
                end
            end
            ACT_DEL_AT, ACT_DEL_RUN: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > held)
                    r.status = ST_RANGE;
                else
                begin
                    // clamp the run to the entries from the position to the back
                    len   = (act == ACT_DEL_AT) ? 1 : int'(run);
                    avail = held - (p - 1);
                    if (len > avail)
                        len = avail;
                    drop_span(p - 1, len);
                end
            end
            ACT_SEARCH: begin
                for (int unsigned i = 0; i < held; i++)
                    if (slots[i] == val)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.fill = held[FILL_W-1:0];
        r.head = (held > 0) ? slots[0] : '0;
        return r;
    endfunction

    function automatic void flag(input string field, input longint want, input longint got);
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        queue_result_t got;
        if (!rst_n)
        begin
            due_results.delete();
            held = 0;
            pending <= 0;
        end
        else
        begin
            // compare a result transfer with the oldest prediction
            if (done)
            begin
                got = {status, found, fill_count, head_value};
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        flag("status", want.status, got.status);
                    if (got.found !== want.found)
                        flag("found", want.found, got.found);
                    if (got.fill !== want.fill)
                        flag("fill_count", want.fill, got.fill);
                    if (got.head !== want.head)
                        flag("head_value", $signed(want.head), $signed(got.head));
                end
            end
            // predict the command transferred at this edge
            if (start && busy === 1'b0)
                due_results.push_back(apply_command(action, value, position, run_length));
            pending <= due_results.size();
        end
    end

endmodule

### tb/sv/positional_queue_engine_test.sv
// Top of the positional queue engine testbench: clock, reset, command stimulus and verdict.
module positional_queue_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pqe_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 100;

    // codes the engine must ignore
    localparam action_t ACT_SPARE_LO = 3'd6;
    localparam action_t ACT_SPARE_HI = 3'd7;

    // cumulative action weights per lean: push, insert, pop, delete, run, search, spare
    localparam int LEAN_FILL  = 0;
    localparam int LEAN_DRAIN = 1;
    localparam int LEAN_MIXED = 2;
    localparam int MIX [3][7] = '{
        '{40, 65, 72, 80, 84, 97, 100},
        '{10, 18, 40, 62, 80, 96, 100},
        '{25, 42, 58, 72, 80, 97, 100}
    };

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    action_t           action     = ACT_PUSH;
    word_t             value      = '0;
    logic [POS_W-1:0]  position   = '0;
    logic [POS_W-1:0]  run_length = '0;
    logic              done;
    status_t           status;
    logic              found;
    logic [FILL_W-1:0] fill_count;
    word_t             head_value;

    int    fail_count;
    int    pending;
    int    cycles     = 0;
    int    burst_left = 0;
    bit    no_gaps    = 1'b0;
    word_t recent_words[$];

    positional_queue_engine #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .position   (position),
        .run_length (run_length),
        .done       (done),
        .status     (status),
        .found      (found),
        .fill_count (fill_count),
        .head_value (head_value)
    );

    queue_result_checker #(
        .DEPTH(DEPTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .position   (position),
        .run_length (run_length),
        .done       (done),
        .status     (status),
        .found      (found),
        .fill_count (fill_count),
        .head_value (head_value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run if the engine stops answering.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("positional_queue_engine_test failed");
            $finish;
        end
    end

    // Present a command and hold it until the transfer edge.
    task automatic send_command(input action_t a, input word_t v,
                                input logic [POS_W-1:0] p, input logic [POS_W-1:0] r);
        start      <= 1'b1;
        action     <= a;
        value      <= v;
        position   <= p;
        run_length <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic rest(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and wait until every predicted result has arrived.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Send in bursts of random length separated by random gaps, unless no_gaps is set.
    task automatic issue_command(input action_t a, input word_t v,
                                 input logic [POS_W-1:0] p, input logic [POS_W-1:0] r);
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                rest($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        send_command(a, v, p, r);
        // remember stored words so searches can hit
        if (a == ACT_PUSH || a == ACT_INS_AT)
        begin
            recent_words.push_back(v);
            if (recent_words.size() > 8)
                void'(recent_words.pop_front());
        end
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            4, 5:    return word_t'($urandom_range(0, 15));
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_index(input int hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return POS_W'($urandom_range(1, 4));
        else if (roll < 9)
            return POS_W'($urandom_range(1, hi));
        return POS_W'($urandom());
    endfunction

    task automatic random_command(input int lean);
        int               roll;
        action_t          a;
        word_t            v;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] r;
        roll = $urandom_range(0, 99);
        if (roll < MIX[lean][0])
            a = ACT_PUSH;
        else if (roll < MIX[lean][1])
            a = ACT_INS_AT;
        else if (roll < MIX[lean][2])
            a = ACT_POP;
        else if (roll < MIX[lean][3])
            a = ACT_DEL_AT;
        else if (roll < MIX[lean][4])
            a = ACT_DEL_RUN;
        else if (roll < MIX[lean][5])
            a = ACT_SEARCH;
        else
            a = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        if (a == ACT_SEARCH && recent_words.size() != 0 && $urandom_range(0, 2) != 0)
            v = recent_words[$urandom_range(0, recent_words.size() - 1)];
        else
            v = pick_word();
        p = pick_index(DEPTH + 1);
        r = pick_index(6);
        issue_command(a, v, p, r);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: every removal is refused, search finds nothing
        issue_command(ACT_POP,     32'h1234_5678, 5'd1, 5'd1);
        issue_command(ACT_DEL_AT,  '0, 5'd1, 5'd1);
        issue_command(ACT_DEL_RUN, '0, 5'd1, 5'd4);
        issue_command(ACT_SEARCH,  '0, 5'd0, 5'd0);
        // insert positions outside 1..fill+1
        issue_command(ACT_INS_AT,  32'h0000_0055, 5'd0, 5'd0);
        issue_command(ACT_INS_AT,  32'h0000_0055, 5'd2, 5'd0);
        // build a queue from the word extremes, inserting at the front and the back
        issue_command(ACT_INS_AT,  32'h8000_0000, 5'd1, 5'd0);
        issue_command(ACT_PUSH,    32'h7FFF_FFFF, 5'd31, 5'd31);
        issue_command(ACT_INS_AT,  32'hFFFF_FFFF, 5'd3, 5'd0);
        issue_command(ACT_INS_AT,  32'h0000_0000, 5'd1, 5'd0);
        issue_command(ACT_SEARCH,  32'hFFFF_FFFF, 5'd0, 5'd0);
        issue_command(ACT_SEARCH,  32'h0000_3039, 5'd0, 5'd0);
        // delete positions outside 1..fill, then a valid one
        issue_command(ACT_DEL_AT,  '0, 5'd0, 5'd1);
        issue_command(ACT_DEL_AT,  '0, 5'd5, 5'd1);
        issue_command(ACT_DEL_AT,  '0, 5'd2, 5'd1);
        // zero-length run, then a run longer than what is left
        issue_command(ACT_DEL_RUN, '0, 5'd1, 5'd0);
        issue_command(ACT_DEL_RUN, '0, 5'd2, 5'd31);
        // unknown codes with every bit of the other fields set
        issue_command(ACT_SPARE_LO, '1, 5'd31, 5'd31);
        issue_command(ACT_SPARE_HI, '1, 5'd31, 5'd31);
        wait_quiet();

        // alternate fill, drain and mixed phases; settle between them
        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_gaps = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_command(ph % 3);
            wait_quiet();
        end

        // let any stray strobe show up
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("positional_queue_engine_test passed");
        else
            $display("positional_queue_engine_test failed");
        $finish;
    end

endmodule

### files.f
design/pqe_pkg.sv
design/pqe_ram.sv
design/positional_queue_engine.sv
tb/sv/queue_result_checker.sv
tb/sv/positional_queue_engine_test.sv
